// ===== sv/bmp24_stream_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// BMP24 decoder assertion macros
// Concurrent assertion wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef BMP24_STREAM_DECODER_ASSERT_SVH
`define BMP24_STREAM_DECODER_ASSERT_SVH

// checked only outside reset
`define BMP24_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BMP24_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bmp24_pkg.sv =====
// ---------------------------------------------------------------------------
// BMP24 decoder package
// Shared types, header offsets and limits for the 24-bit BMP stream decoder.
// ---------------------------------------------------------------------------
package bmp24_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);   // holds 1..MAX_DIM
  localparam int CNT_W   = $clog2(MAX_DIM);       // holds 0..MAX_DIM-1
  localparam int POS_W   = 12;

  localparam logic [31:0] MAX_DIM_W32 = 32'(MAX_DIM);

  // header byte offsets
  localparam logic [5:0] HDR_SIG    = 6'd0;
  localparam logic [5:0] HDR_WIDTH  = 6'd18;
  localparam logic [5:0] HDR_HEIGHT = 6'd22;
  localparam logic [5:0] HDR_DEPTH  = 6'd28;
  localparam logic [5:0] HDR_LAST   = 6'd53;

  localparam logic [15:0] SIG_BM   = 16'h4D42;
  localparam logic [15:0] BPP_24   = 16'd24;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    KIND_PIXEL,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SIGNATURE,
    ERR_DEPTH,
    ERR_DIMS,
    ERR_TRUNCATED
  } err_code_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    err_code_t        err;
    logic             last;
  } result_t;

  // head of the result queue as seen by the output stage
  typedef struct packed {
    logic    valid;
    result_t data;
  } q_head_t;

endpackage

// ===== sv/bmp24_parser.sv =====
// ---------------------------------------------------------------------------
// BMP24 parser
// Front end: takes file bytes, captures the header, checks it and turns
// blue/green/red byte triples into pixel results, skipping row padding.
// ---------------------------------------------------------------------------
module bmp24_parser
  import bmp24_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       emit,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXEL,
    PH_PAD,
    PH_IDLE
  } phase_t;

  phase_t           phase, phase_next;
  logic [5:0]       header_count, header_count_next;
  logic [15:0]      signature_word, signature_word_next;
  logic [15:0]      depth_word, depth_word_next;
  logic [31:0]      width_word, width_word_next;
  logic [31:0]      height_word, height_word_next;
  logic             top_down, top_down_next;
  logic [DIM_W-1:0] dim_w, dim_w_next;
  logic [DIM_W-1:0] dim_h, dim_h_next;
  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [1:0]       comp_index, comp_index_next;
  logic [1:0]       pad_remaining, pad_remaining_next;
  logic [7:0]       blue_hold, blue_hold_next;
  logic [7:0]       green_hold, green_hold_next;

  logic [31:0]      abs_height;
  logic             dims_bad;
  logic             sig_sel, depth_sel;
  logic [1:0]       width_sel, height_sel;
  logic [DIM_W-1:0] col_plus, row_plus, y_up;
  logic             last;

  assign abs_height = height_word[31] ? (~height_word + 32'd1) : height_word;
  assign dims_bad   = width_word[31] || (width_word == '0) || (width_word > MAX_DIM_W32) ||
                      (abs_height == '0) || (abs_height > MAX_DIM_W32);

  assign sig_sel    = 1'(header_count - HDR_SIG);
  assign width_sel  = 2'(header_count - HDR_WIDTH);
  assign height_sel = 2'(header_count - HDR_HEIGHT);
  assign depth_sel  = 1'(header_count - HDR_DEPTH);

  assign col_plus = DIM_W'(column_count) + DIM_W'(1);
  assign row_plus = DIM_W'(row_count) + DIM_W'(1);
  assign y_up     = dim_h - DIM_W'(1) - DIM_W'(row_count);
  assign last     = (col_plus == dim_w) && (row_plus == dim_h);

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    signature_word_next = signature_word;
    depth_word_next     = depth_word;
    width_word_next     = width_word;
    height_word_next    = height_word;
    top_down_next       = top_down;
    dim_w_next          = dim_w;
    dim_h_next          = dim_h;
    column_count_next   = column_count;
    row_count_next      = row_count;
    comp_index_next     = comp_index;
    pad_remaining_next  = pad_remaining;
    blue_hold_next      = blue_hold;
    green_hold_next     = green_hold;
    emit                = 1'b0;
    res                 = '0;

    if (accept) begin
      if (in_end) begin
        phase_next          = PH_HEADER;
        header_count_next   = '0;
        signature_word_next = '0;
        depth_word_next     = '0;
        width_word_next     = '0;
        height_word_next    = '0;
        top_down_next       = 1'b0;
        column_count_next   = '0;
        row_count_next      = '0;
        comp_index_next     = '0;
        pad_remaining_next  = '0;
        if (phase != PH_IDLE) begin
          emit     = 1'b1;
          res.kind = KIND_ERROR;
          res.err  = ERR_TRUNCATED;
        end
      end else begin
        case (phase)
          PH_HEADER: begin
            header_count_next = header_count + 6'd1;
            if (header_count inside {[HDR_SIG : HDR_SIG + 6'd1]}) begin
              signature_word_next[{sig_sel, 3'b000} +: 8] = in_byte;
            end else if (header_count inside {[HDR_WIDTH : HDR_WIDTH + 6'd3]}) begin
              width_word_next[{width_sel, 3'b000} +: 8] = in_byte;
            end else if (header_count inside {[HDR_HEIGHT : HDR_HEIGHT + 6'd3]}) begin
              height_word_next[{height_sel, 3'b000} +: 8] = in_byte;
            end else if (header_count inside {[HDR_DEPTH : HDR_DEPTH + 6'd1]}) begin
              depth_word_next[{depth_sel, 3'b000} +: 8] = in_byte;
            end
            // byte 53 carries nothing we keep, so checks use the stored words
            if (header_count == HDR_LAST) begin
              if (signature_word != SIG_BM) begin
                emit       = 1'b1;
                res.kind   = KIND_ERROR;
                res.err    = ERR_SIGNATURE;
                phase_next = PH_IDLE;
              end else if (depth_word != BPP_24) begin
                emit       = 1'b1;
                res.kind   = KIND_ERROR;
                res.err    = ERR_DEPTH;
                phase_next = PH_IDLE;
              end else if (dims_bad) begin
                emit       = 1'b1;
                res.kind   = KIND_ERROR;
                res.err    = ERR_DIMS;
                phase_next = PH_IDLE;
              end else begin
                phase_next         = PH_PIXEL;
                top_down_next      = height_word[31];
                dim_w_next         = width_word[DIM_W-1:0];
                dim_h_next         = abs_height[DIM_W-1:0];
                column_count_next  = '0;
                row_count_next     = '0;
                comp_index_next    = '0;
                pad_remaining_next = '0;
              end
            end
          end
          PH_PIXEL: begin
            case (comp_index)
              2'd0: begin
                blue_hold_next  = in_byte;
                comp_index_next = 2'd1;
              end
              2'd1: begin
                green_hold_next = in_byte;
                comp_index_next = 2'd2;
              end
              default: begin
                comp_index_next = 2'd0;
                emit            = 1'b1;
                res.kind        = KIND_PIXEL;
                res.pos_x       = POS_W'(column_count);
                res.pos_y       = top_down ? POS_W'(row_count) : POS_W'(y_up);
                res.red         = in_byte;
                res.green       = green_hold;
                res.blue        = blue_hold;
                res.last        = last;
                if (last) begin
                  phase_next = PH_IDLE;
                end else if (col_plus == dim_w) begin
                  column_count_next  = '0;
                  row_count_next     = CNT_W'(row_plus);
                  pad_remaining_next = dim_w[1:0];
                  if (dim_w[1:0] != 2'd0) begin
                    phase_next = PH_PAD;
                  end
                end else begin
                  column_count_next = CNT_W'(col_plus);
                end
              end
            endcase
          end
          PH_PAD: begin
            if (pad_remaining != 2'd0) begin
              pad_remaining_next = pad_remaining - 2'd1;
            end
            if (pad_remaining <= 2'd1) begin
              phase_next = PH_PIXEL;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      signature_word <= '0;
      depth_word     <= '0;
      width_word     <= '0;
      height_word    <= '0;
      top_down       <= 1'b0;
      column_count   <= '0;
      row_count      <= '0;
      comp_index     <= '0;
      pad_remaining  <= '0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      signature_word <= signature_word_next;
      depth_word     <= depth_word_next;
      width_word     <= width_word_next;
      height_word    <= height_word_next;
      top_down       <= top_down_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      comp_index     <= comp_index_next;
      pad_remaining  <= pad_remaining_next;
    end
    dim_w      <= dim_w_next;
    dim_h      <= dim_h_next;
    blue_hold  <= blue_hold_next;
    green_hold <= green_hold_next;
  end

endmodule

// ===== sv/bmp24_fifo.sv =====
// ---------------------------------------------------------------------------
// BMP24 result queue
// Short first-word-fall-through queue between the parser and output stage.
// ---------------------------------------------------------------------------
module bmp24_fifo
  import bmp24_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bmp24_out.sv =====
// ---------------------------------------------------------------------------
// BMP24 output stage
// Back end: pulls results off the queue into the master-side register.
// ---------------------------------------------------------------------------
module bmp24_out
  import bmp24_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_head_t     head,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  assign pop = head.valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= head.valid;
    end
    if (pop) begin
      m_axis_tdata <= {6'b0, head.data.err, head.data.blue, head.data.green,
                       head.data.red, head.data.pos_y, head.data.pos_x};
      m_axis_tuser <= head.data.kind;
      m_axis_tlast <= head.data.last;
    end
  end

endmodule

// ===== sv/bmp24_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// 24-bit BMP stream decoder
// Parses a BMP file byte by byte and emits one word per pixel or error.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                                        tuser  tlast
//  s_axis   in   [7:0] file byte                              -      end of file
//  m_axis   out  [11:0] x, [23:12] y, [31:24] red,            kind   last pixel
//                [39:32] green, [47:40] blue, [49:48] error
//
//  One byte is taken every cycle while the result queue is not full; a result
//  is written into the result queue and then into the m_axis output register.
//  s_axis_tready falls only when the four-word result queue is full, i.e.
//  after m_axis has been stalled for several results.
//  Synchronous reset clears the parser and queue.
// ---------------------------------------------------------------------------
module bmp24_stream_decoder
  import bmp24_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // pos_x, pos_y, red, green, blue, error_code
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast
);

  logic    accept;
  logic    emit;
  result_t res;
  logic    full;
  logic    pop;
  q_head_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bmp24_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_axis_tdata),
    .in_end  (s_axis_tlast),
    .emit    (emit),
    .res     (res)
  );

  bmp24_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (res),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

  bmp24_out u_out (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== sv/bmp24_checker.sv =====
// ---------------------------------------------------------------------------
// BMP24 port checker
// Watches the decoder ports for output handshake and result format slips.
// ---------------------------------------------------------------------------
`include "bmp24_stream_decoder_assert.svh"

module bmp24_checker
  import bmp24_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic err_word;
  logic pix_word;

  assign err_word = m_axis_tvalid && (m_axis_tuser == KIND_ERROR);
  assign pix_word = m_axis_tvalid && (m_axis_tuser == KIND_PIXEL);

  `BMP24_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid, "output valid after reset")

  `BMP24_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

  `BMP24_ASSERT(a_err_clean, err_word |-> (m_axis_tdata[47:0] == '0) && !m_axis_tlast && (m_axis_tdata[55:50] == '0), "error word carries pixel fields")

  `BMP24_ASSERT(a_pix_clean, pix_word |-> (m_axis_tdata[55:48] == '0), "pixel word carries an error code")

endmodule

bind bmp24_stream_decoder bmp24_checker u_bmp24_checker (.*);

// ===== sim/bmp24_stream_checker.sv =====
// ---------------------------------------------------------------------------
// BMP24 stream decoder checker
// Watches both stream channels, predicts every pixel or error word from the
// accepted file bytes and compares each output word field by field.
// ---------------------------------------------------------------------------
module bmp24_stream_checker
  import bmp24_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // stream_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // [11:0] pos_x, [23:12] pos_y, [31:24] red,
                                      // [39:32] green, [47:40] blue, [49:48] error_code
  input  logic        m_axis_tuser,   // result_kind
  input  logic        m_axis_tlast,   // last_pixel
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } parse_phase_t;

  parse_phase_t phase;
  int           hdr_cnt;
  logic [15:0]  sig;
  logic [15:0]  bpp;
  logic [31:0]  img_w;
  logic [31:0]  img_h;
  logic [31:0]  col;
  logic [31:0]  row;
  logic         top_down;
  logic [1:0]   comp;
  logic [1:0]   pad_left;
  logic [7:0]   blue_q;
  logic [7:0]   green_q;
  result_t      expected_q[$];

  function automatic void clear_decoder();
    phase    = PH_HEADER;
    hdr_cnt  = 0;
    sig      = '0;
    bpp      = '0;
    img_w    = '0;
    img_h    = '0;
    col      = '0;
    row      = '0;
    top_down = 1'b0;
    comp     = '0;
    pad_left = '0;
    blue_q   = '0;
    green_q  = '0;
  endfunction

  function automatic logic [31:0] height_mag();
    return img_h[31] ? (~img_h + 32'd1) : img_h;
  endfunction

  // returns 1 when the word produces an output word, placed in r
  function automatic bit decode_word(input logic [7:0] b, input logic eos,
                                     output result_t r);
    logic [31:0] mag;
    logic [31:0] ypos;
    logic        fin;
    r = '0;
    if (eos) begin
      fin = (phase != PH_DONE);
      clear_decoder();
      if (fin) begin
        r.kind = KIND_ERROR;
        r.err  = ERR_TRUNCATED;
      end
      return fin;
    end
    case (phase)
      PH_HEADER: begin
        if (hdr_cnt < 2)
          sig[8*hdr_cnt +: 8] = b;
        else if (hdr_cnt >= 18 && hdr_cnt < 22)
          img_w[8*(hdr_cnt-18) +: 8] = b;
        else if (hdr_cnt >= 22 && hdr_cnt < 26)
          img_h[8*(hdr_cnt-22) +: 8] = b;
        else if (hdr_cnt >= 28 && hdr_cnt < 30)
          bpp[8*(hdr_cnt-28) +: 8] = b;
        hdr_cnt++;
        if (hdr_cnt < 54)
          return 1'b0;
        mag    = height_mag();
        r.kind = KIND_ERROR;
        phase  = PH_DONE;
        // checks run in a fixed order; first failure wins
        if (sig != SIG_BM)
          r.err = ERR_SIGNATURE;
        else if (bpp != BPP_24)
          r.err = ERR_DEPTH;
        else if (img_w[31] || img_w == 0 || img_w > MAX_DIM_W32 ||
                 mag == 0 || mag > MAX_DIM_W32)
          r.err = ERR_DIMS;
        else begin
          r.kind   = KIND_PIXEL;
          top_down = img_h[31];
          col      = '0;
          row      = '0;
          comp     = '0;
          pad_left = '0;
          phase    = PH_PIXEL;
          return 1'b0;
        end
        return 1'b1;
      end
      PH_PIXEL: begin
        if (comp == 2'd0) begin
          blue_q = b;
          comp   = 2'd1;
          return 1'b0;
        end
        if (comp == 2'd1) begin
          green_q = b;
          comp    = 2'd2;
          return 1'b0;
        end
        comp    = 2'd0;
        mag     = height_mag();
        ypos    = top_down ? row : (mag - 32'd1 - row);
        fin     = (col + 32'd1 == img_w) && (row + 32'd1 == mag);
        r.kind  = KIND_PIXEL;
        r.pos_x = col[POS_W-1:0];
        r.pos_y = ypos[POS_W-1:0];
        r.red   = b;
        r.green = green_q;
        r.blue  = blue_q;
        r.last  = fin;
        col++;
        if (fin)
          phase = PH_DONE;
        else if (col >= img_w) begin
          col      = '0;
          row++;
          pad_left = img_w[1:0];
          if (pad_left != 2'd0)
            phase = PH_PAD;
        end
        return 1'b1;
      end
      PH_PAD: begin
        if (pad_left != 2'd0)
          pad_left--;
        if (pad_left == 2'd0)
          phase = PH_PIXEL;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("kind=%0d x=%0d y=%0d r=%02h g=%02h b=%02h err=%0d last=%0b",
                     r.kind, r.pos_x, r.pos_y, r.red, r.green, r.blue, r.err, r.last);
  endfunction

  always @(posedge clk) begin
    result_t nxt;
    result_t got;
    result_t want;
    if (rst) begin
      clear_decoder();
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_word(s_axis_tdata, s_axis_tlast, nxt))
          expected_q.push_back(nxt);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = kind_t'(m_axis_tuser);
        got.pos_x = m_axis_tdata[11:0];
        got.pos_y = m_axis_tdata[23:12];
        got.red   = m_axis_tdata[31:24];
        got.green = m_axis_tdata[39:32];
        got.blue  = m_axis_tdata[47:40];
        got.err   = err_code_t'(m_axis_tdata[49:48]);
        got.last  = m_axis_tlast;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: %s", describe(got));
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected %s", describe(want));
              $display("          actual   %s", describe(got));
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// BMP24 stream decoder testbench
// Feeds whole and broken BMP files byte by byte under varying source gaps and
// sink back-pressure; the checker predicts and compares every output word.
// ---------------------------------------------------------------------------
module tb_top;
  import bmp24_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] data_byte
  logic        s_axis_tlast;    // stream_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;    // [11:0] pos_x, [23:12] pos_y, [31:24] red,
                                // [39:32] green, [47:40] blue, [49:48] error_code
  logic        m_axis_tuser;    // result_kind
  logic        m_axis_tlast;    // last_pixel
  int          fail_count;
  int          pending;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          fed;
  int          quiet     = 0;
  logic [7:0]  file_q[$];

  always #10 clk = ~clk;

  bmp24_stream_decoder dut (.*);
  bmp24_stream_checker chk (.*);

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("** bmp24_stream_decoder: FAILED **");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // first n bytes of the file, then end of stream
  task automatic send_file(input int n);
    for (int i = 0; i < n; i++)
      send_word(file_q[i], 1'b0);
    send_word(8'($urandom), 1'b1);
    fed += n;
  endtask

  task automatic add_noise(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  task automatic build_header(input logic [15:0] s, input logic [31:0] w,
                              input logic [31:0] h, input logic [15:0] d);
    file_q.delete();
    add_noise(54);
    file_q[0] = s[7:0];
    file_q[1] = s[15:8];
    for (int i = 0; i < 4; i++) begin
      file_q[18+i] = w[8*i +: 8];
      file_q[22+i] = h[8*i +: 8];
    end
    file_q[28] = d[7:0];
    file_q[29] = d[15:8];
  endtask

  // valid header plus full pixel data, padding after the last row included
  task automatic build_image(input int w, input int h);
    int hm;
    hm = (h < 0) ? -h : h;
    build_header(SIG_BM, w, h, BPP_24);
    add_noise(hm * (3 * w + w % 4));
  endtask

  task automatic send_bad_dims(input int w, input int h);
    build_header(SIG_BM, w, h, BPP_24);
    add_noise(4);
    send_file(file_q.size());
  endtask

  task automatic random_file();
    int sel;
    int w;
    int hm;
    int h;
    int n;
    sel = $urandom_range(99);
    w   = $urandom_range(1, 6);
    hm  = $urandom_range(1, 4);
    h   = $urandom_range(1) ? -hm : hm;
    if (sel < 70)
      build_image(w, h);
    else if (sel < 76) begin
      build_header(SIG_BM ^ (16'd1 << $urandom_range(15)), w, h, BPP_24);
      add_noise($urandom_range(8));
    end else if (sel < 82) begin
      build_header(SIG_BM, w, h, BPP_24 ^ (16'd1 << $urandom_range(15)));
      add_noise($urandom_range(8));
    end else if (sel < 90) begin
      case ($urandom_range(5))
        0: w = 0;
        1: w = MAX_DIM + 1 + $urandom_range(100);
        2: w = $urandom | 32'h8000_0000;
        3: h = 0;
        4: h = ($urandom_range(1) ? -1 : 1) * (MAX_DIM + 1 + $urandom_range(100));
        default: h = 32'h8000_0000;
      endcase
      build_header(SIG_BM, w, h, BPP_24);
      add_noise($urandom_range(8));
    end else if (sel < 97) begin
      file_q.delete();
      add_noise($urandom_range(54, 70));
    end else
      file_q.delete();
    n = file_q.size();
    if (n > 0 && $urandom_range(99) < 15)
      n = $urandom_range(n - 1);
    else if ($urandom_range(99) < 10) begin
      add_noise($urandom_range(1, 6));
      n = file_q.size();
    end
    send_file(n);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    fed           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty streams, back to back
    file_q.delete();
    send_file(0);
    send_file(0);
    // good images: bottom-up with padding, top-down, junk after the final pixel
    build_image(3, 2);
    send_file(file_q.size());
    build_image(4, -3);
    send_file(file_q.size());
    build_image(5, -1);
    add_noise(7);
    send_file(file_q.size());
    build_image(1, 3);
    send_file(file_q.size());
    // header errors in priority order, trailing bytes ignored
    build_header(16'h4D43, 2, 2, BPP_24);
    add_noise(5);
    send_file(file_q.size());
    build_header(16'h424D, 2, 2, 16'd32);
    send_file(file_q.size());
    build_header(SIG_BM, 2, 0, 16'd32);
    send_file(file_q.size());
    build_header(SIG_BM, 2, 2, 16'h0118);
    send_file(file_q.size());
    send_bad_dims(0, 1);
    send_bad_dims(MAX_DIM + 1, 1);
    send_bad_dims(-1, 1);
    send_bad_dims(1, 0);
    send_bad_dims(1, MAX_DIM + 1);
    send_bad_dims(1, -(MAX_DIM + 1));
    send_bad_dims(1, 32'h8000_0000);
    // early ends: inside the header, right after it, mid-pixel, inside padding
    build_image(2, 2);
    send_file(20);
    send_file(54);
    send_file(55);
    send_file(61);
    // largest accepted size, bottom-up; the stream stops two pixels in
    build_header(SIG_BM, MAX_DIM, MAX_DIM, BPP_24);
    add_noise(6);
    send_file(file_q.size());

    fed = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 79;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 79;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      while (fed < PHASE_BYTES * (ph + 1))
        random_file();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("** bmp24_stream_decoder: PASSED **");
    else
      $display("** bmp24_stream_decoder: FAILED **");
    $finish;
  end

endmodule
